// ===== rtl/core/lcsra_pkg.sv =====
// Package for the load-cell serial read, averaging and scaling block.
// Holds widths, register indexes, reset values and scaling constants.
// No dependencies.
`default_nettype none

package lcsra_pkg;

   localparam int DATA_BITS = 24;
   localparam int BIT_CNT_W = $clog2(DATA_BITS + 2);
   localparam int SUM_W     = 40;
   localparam int AVG_W     = 24;
   localparam int TARE_W    = 24;
   localparam int DIV_W     = 32;
   localparam int CNT_W     = 16;
   localparam int WEIGHT_W  = 34;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARE_VALUE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_DIVISOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_PERIOD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_TICKS     = 3'd4;

   localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 16'd20;
   localparam logic [TARE_W-1:0] TARE_VALUE_RST   = 24'd0;
   localparam logic [DIV_W-1:0]  SCALE_DIV_RST    = 32'd11024;
   localparam logic [CNT_W-1:0]  HALF_PERIOD_RST  = 16'd40;
   localparam logic [CNT_W-1:0]  GAP_TICKS_RST    = 16'd10;

   localparam longint SCALE_FACTOR = 1000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
   localparam longint Q_LIMIT   = ((longint'(1) << WEIGHT_W) - 1) / SCALE_FACTOR;
   localparam int     Q_W       = $clog2(Q_LIMIT + 1);
   localparam int     PROD_W    = WEIGHT_W + 1;

endpackage

`default_nettype wire

// ===== rtl/core/load_cell_serial_read_average_scale_top.sv =====
// Top level: one item per tick in, one result item per tick out, registered.
// An ordinary tick has its result item valid in the cycle after it is accepted.
// The tick that ends a measurement has its result item after two 40-step divisions
// in the shared serial divider and then scaling; only the first division runs when the
// average does not exceed the tare. A stalled result output delays it further.
// Synchronous active-high reset sets default configuration and empties the output.
`default_nettype none

module load_cell_serial_read_average_scale_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_cmd,
   input  wire logic                               req_data_pin,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_clock_pin,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic [lcsra_pkg::AVG_W-1:0]             rsp_average_raw,
   output logic [lcsra_pkg::WEIGHT_W-1:0]          rsp_weight,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lcsra_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lcsra_pkg::CSR_DAT_W-1:0]    csr_data
);
   import lcsra_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_GAP,
      PH_AVG_GO, PH_AVG_RUN, PH_SCALE_GO, PH_SCALE_RUN, PH_MUL, PH_OUT
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [CNT_W-1:0]       tick_ff, tick_in;
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       taken_ff, taken_in;
   logic                   clk_lvl_ff, clk_lvl_in;
   logic [SUM_W-1:0]       avg_ff, avg_in;
   logic [WEIGHT_W-1:0]    weight_ff, weight_in;

   logic [CNT_W-1:0]       count_cfg_ff;
   logic [TARE_W-1:0]      tare_cfg_ff;
   logic [DIV_W-1:0]       div_cfg_ff;
   logic [CNT_W-1:0]       half_cfg_ff;
   logic [CNT_W-1:0]       gap_cfg_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_clock_pin_ff, rsp_clock_pin_in;
   logic                   rsp_busy_ff, rsp_busy_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic [AVG_W-1:0]       rsp_avg_ff, rsp_avg_in;
   logic [WEIGHT_W-1:0]    rsp_weight_ff, rsp_weight_in;
   logic                   rsp_load;

   logic                   tick_phase;
   logic                   slot_free;
   logic                   req_fire;
   logic [CNT_W-1:0]       eff_count;
   logic [DIV_W-1:0]       eff_div;
   logic [CNT_W:0]         tick_inc;
   logic [SUM_W-1:0]       tare_ext;
   logic                   above_tare;
   logic                   div_start;
   logic [SUM_W-1:0]       div_dividend;
   logic [DIV_W-1:0]       div_divisor;
   logic                   div_done;
   logic [SUM_W-1:0]       div_quotient;
   logic [PROD_W-1:0]      product;
   logic                   leave_gap;
   logic                   finish;

   assign tick_phase = (phase_ff == PH_IDLE) || (phase_ff == PH_WAIT) ||
                       (phase_ff == PH_HIGH) || (phase_ff == PH_LOW) ||
                       (phase_ff == PH_GAP);
   assign slot_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready  = tick_phase & slot_free;
   assign req_fire   = req_valid & req_ready;
   assign csr_ready  = 1'b1;

   assign eff_count  = (count_cfg_ff == '0) ? CNT_W'(1) : count_cfg_ff;
   assign eff_div    = (div_cfg_ff == '0) ? DIV_W'(1) : div_cfg_ff;
   assign tick_inc   = {1'b0, tick_ff} + 1'b1;
   assign tare_ext   = SUM_W'(tare_cfg_ff);
   assign above_tare = avg_ff > tare_ext;
   assign product    = PROD_W'(div_quotient[Q_W-1:0]) * PROD_W'(SCALE_FACTOR);

   assign div_start    = (phase_ff == PH_AVG_GO) || ((phase_ff == PH_SCALE_GO) && above_tare);
   assign div_dividend = (phase_ff == PH_AVG_GO) ? sum_ff : avg_ff - tare_ext;
   assign div_divisor  = (phase_ff == PH_AVG_GO) ? DIV_W'(eff_count) : eff_div;

   lcsra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      sum_in        = sum_ff;
      taken_in      = taken_ff;
      clk_lvl_in    = clk_lvl_ff;
      avg_in        = avg_ff;
      weight_in     = weight_ff;
      leave_gap     = 1'b0;
      finish        = 1'b0;
      rsp_load      = 1'b0;
      rsp_clock_pin_in = rsp_clock_pin_ff;
      rsp_busy_in   = rsp_busy_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_weight_in = rsp_weight_ff;

      case (phase_ff)
         PH_IDLE: begin
            if (req_fire && req_cmd) begin
               sum_in   = '0;
               taken_in = '0;
               tick_in  = '0;
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (req_fire && !req_data_pin) begin
               shift_in   = '0;
               bit_in     = '0;
               clk_lvl_in = 1'b1;
               tick_in    = CNT_W'(1);
               phase_in   = PH_HIGH;
            end
         end
         PH_HIGH: begin
            if (req_fire) begin
               if (tick_ff >= half_cfg_ff) begin
                  clk_lvl_in = 1'b0;
                  tick_in    = CNT_W'(1);
                  phase_in   = PH_LOW;
               end else begin
                  tick_in = tick_inc[CNT_W-1:0];
               end
            end
         end
         PH_LOW: begin
            if (req_fire) begin
               if (tick_ff >= half_cfg_ff) begin
                  if (bit_ff < BIT_CNT_W'(DATA_BITS)) begin
                     shift_in = {shift_ff[DATA_BITS-2:0], req_data_pin};
                  end
                  bit_in = bit_ff + 1'b1;
                  if (bit_ff < BIT_CNT_W'(DATA_BITS)) begin
                     clk_lvl_in = 1'b1;
                     tick_in    = CNT_W'(1);
                     phase_in   = PH_HIGH;
                  end else begin
                     sum_in   = sum_ff + SUM_W'(shift_ff);
                     taken_in = taken_ff + 1'b1;
                     tick_in  = '0;
                     if (gap_cfg_ff == '0) begin
                        leave_gap = 1'b1;
                     end else begin
                        phase_in = PH_GAP;
                     end
                  end
               end else begin
                  tick_in = tick_inc[CNT_W-1:0];
               end
            end
         end
         PH_GAP: begin
            if (req_fire) begin
               tick_in = tick_inc[CNT_W-1:0];
               if (tick_inc >= {1'b0, gap_cfg_ff}) begin
                  leave_gap = 1'b1;
               end
            end
         end
         PH_AVG_GO: begin
            phase_in = PH_AVG_RUN;
         end
         PH_AVG_RUN: begin
            if (div_done) begin
               avg_in   = div_quotient;
               phase_in = PH_SCALE_GO;
            end
         end
         PH_SCALE_GO: begin
            if (above_tare) begin
               phase_in = PH_SCALE_RUN;
            end else begin
               weight_in = '0;
               phase_in  = PH_OUT;
            end
         end
         PH_SCALE_RUN: begin
            if (div_done) begin
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            weight_in = (div_quotient > SUM_W'(Q_LIMIT)) ? WEIGHT_MAX
                                                         : product[WEIGHT_W-1:0];
            phase_in  = PH_OUT;
         end
         PH_OUT: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_clock_pin_in = clk_lvl_ff;
               rsp_busy_in      = 1'b0;
               rsp_done_in      = 1'b1;
               rsp_avg_in       = avg_ff[AVG_W-1:0];
               rsp_weight_in    = weight_ff;
               phase_in         = PH_IDLE;
               tick_in          = '0;
            end
         end
         default: begin
            phase_in   = PH_IDLE;
            clk_lvl_in = 1'b0;
            tick_in    = '0;
         end
      endcase

      if (leave_gap) begin
         tick_in = '0;
         if (taken_in >= eff_count) begin
            finish   = 1'b1;
            phase_in = PH_AVG_GO;
         end else begin
            phase_in = PH_WAIT;
         end
      end

      if (req_fire && !finish) begin
         rsp_load         = 1'b1;
         rsp_clock_pin_in = clk_lvl_in;
         rsp_busy_in      = (phase_in != PH_IDLE);
         rsp_done_in      = 1'b0;
         rsp_avg_in       = '0;
         rsp_weight_in    = '0;
      end

      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         taken_ff     <= '0;
         clk_lvl_ff   <= 1'b0;
         shift_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_cfg_ff <= SAMPLE_COUNT_RST;
         tare_cfg_ff  <= TARE_VALUE_RST;
         div_cfg_ff   <= SCALE_DIV_RST;
         half_cfg_ff  <= HALF_PERIOD_RST;
         gap_cfg_ff   <= GAP_TICKS_RST;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         taken_ff     <= taken_in;
         clk_lvl_ff   <= clk_lvl_in;
         shift_ff     <= shift_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SAMPLE_COUNT:  count_cfg_ff <= csr_data[CNT_W-1:0];
               REG_TARE_VALUE:    tare_cfg_ff  <= csr_data[TARE_W-1:0];
               REG_SCALE_DIVISOR: div_cfg_ff   <= csr_data[DIV_W-1:0];
               REG_HALF_PERIOD:   half_cfg_ff  <= csr_data[CNT_W-1:0];
               REG_GAP_TICKS:     gap_cfg_ff   <= csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
      end
      avg_ff           <= avg_in;
      weight_ff        <= weight_in;
      rsp_clock_pin_ff <= rsp_clock_pin_in;
      rsp_busy_ff      <= rsp_busy_in;
      rsp_done_ff      <= rsp_done_in;
      rsp_avg_ff       <= rsp_avg_in;
      rsp_weight_ff    <= rsp_weight_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_clock_pin   = rsp_clock_pin_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_average_raw = rsp_avg_ff;
   assign rsp_weight      = rsp_weight_ff;

`ifndef SYNTHESIS
   a_no_tick_while_dividing: assert property (@(posedge clock) disable iff (reset)
      !tick_phase |-> !req_ready)
      else $error("item accepted while the result is being computed");

   a_div_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (phase_ff == PH_AVG_RUN || phase_ff == PH_SCALE_RUN))
      else $error("divider finished outside a division phase");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
      else $error("finished result item still reports busy");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= BIT_CNT_W'(DATA_BITS + 1))
      else $error("bit counter ran past the last clock pulse");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lcsra_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Shared for the average and the scaled weight; depends on lcsra_pkg.
`default_nettype none

module lcsra_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lcsra_pkg::SUM_W-1:0]   dividend,
   input  wire logic [lcsra_pkg::DIV_W-1:0]   divisor,
   output logic                               done,
   output logic [lcsra_pkg::SUM_W-1:0]        quotient
);
   import lcsra_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam logic [STEP_W-1:0] STEPS = STEP_W'(SUM_W);

   logic              run_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  rem_in;
   logic [SUM_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  quo_in;
   logic [DIV_W-1:0]  dsr_ff;
   logic [DIV_W:0]    rem_shift;
   logic [DIV_W+1:0]  trial;
   logic              fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, dsr_ff};
      fits      = ~trial[DIV_W+1];
      rem_in    = fits ? trial[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      quo_in    = {quo_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= STEPS;
         end else if (run_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the load-cell serial read, averaging and scaling block.
// Sends converter ticks and register writes, follows the read sequencer tick by tick
// and checks every result item; needs only lcsra_pkg and the RTL top level.
module tb_top;
   import lcsra_pkg::*;

   typedef enum logic [2:0] {P_IDLE, P_WAIT, P_HIGH, P_LOW, P_GAP} read_phase_type;

   typedef struct packed {
      logic                clock_pin;
      logic                busy;
      logic                done;
      logic [AVG_W-1:0]    average;
      logic [WEIGHT_W-1:0] weight;
   } tick_report_type;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int STUCK_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 100;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_cmd;
   logic                 req_data_pin;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_clock_pin;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic [AVG_W-1:0]     rsp_average_raw;
   logic [WEIGHT_W-1:0]  rsp_weight;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   logic [CNT_W-1:0]     cfg_readings;
   logic [TARE_W-1:0]    cfg_tare;
   logic [DIV_W-1:0]     cfg_divisor;
   logic [CNT_W-1:0]     cfg_half;
   logic [CNT_W-1:0]     cfg_gap;

   read_phase_type       rd_phase;
   logic [CNT_W-1:0]     rd_ticks;
   logic [BIT_CNT_W-1:0] rd_bits;
   logic [DATA_BITS-1:0] rd_shift;
   logic [SUM_W-1:0]     rd_sum;
   logic [CNT_W-1:0]     rd_taken;
   logic                 rd_clock;

   logic                 fin_done;
   logic [AVG_W-1:0]     fin_avg;
   logic [WEIGHT_W-1:0]  fin_weight;

   tick_report_type      tick_reports[$];
   logic [DATA_BITS-1:0] read_word;
   bit                   word_fixed;
   bit                   calm;
   int                   hold_left;
   int                   run_left;
   int                   stuck_cycles = 0;
   int                   bad_reports;
   int                   sent_items;

   load_cell_serial_read_average_scale_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_data_pin    (req_data_pin),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_clock_pin   (rsp_clock_pin),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_average_raw (rsp_average_raw),
      .rsp_weight      (rsp_weight),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   function automatic void end_of_reading();
      logic [63:0] count;
      logic [63:0] mean;
      logic [63:0] divisor;
      logic [63:0] quotient;
      logic [63:0] scaled;
      count = (cfg_readings == '0) ? 64'd1 : 64'(cfg_readings);
      if (64'(rd_taken) < count) begin
         rd_phase = P_WAIT;
         rd_ticks = '0;
         return;
      end
      mean = 64'(rd_sum) / count;
      divisor = (cfg_divisor == '0) ? 64'd1 : 64'(cfg_divisor);
      scaled = '0;
      if (mean > 64'(cfg_tare)) begin
         quotient = (mean - 64'(cfg_tare)) / divisor;
         if (quotient > 64'(WEIGHT_MAX) / 64'(SCALE_FACTOR)) begin
            scaled = 64'(WEIGHT_MAX);
         end else begin
            scaled = quotient * 64'(SCALE_FACTOR);
         end
      end
      fin_done = 1'b1;
      fin_avg = mean[AVG_W-1:0];
      fin_weight = scaled[WEIGHT_W-1:0];
      rd_phase = P_IDLE;
      rd_ticks = '0;
   endfunction

   function automatic void step_converter_read(input logic cmd, input logic pin);
      tick_report_type rep;
      fin_done = 1'b0;
      fin_avg = '0;
      fin_weight = '0;
      case (rd_phase)
         P_IDLE: begin
            if (cmd) begin
               rd_sum = '0;
               rd_taken = '0;
               rd_phase = P_WAIT;
               rd_ticks = '0;
            end
         end
         P_WAIT: begin
            if (!pin) begin
               rd_shift = '0;
               rd_bits = '0;
               rd_clock = 1'b1;
               rd_ticks = 16'd1;
               rd_phase = P_HIGH;
            end
         end
         P_HIGH: begin
            if (rd_ticks >= cfg_half) begin
               rd_clock = 1'b0;
               rd_ticks = 16'd1;
               rd_phase = P_LOW;
            end else begin
               rd_ticks = rd_ticks + 16'd1;
            end
         end
         P_LOW: begin
            if (rd_ticks >= cfg_half) begin
               if (rd_bits < BIT_CNT_W'(DATA_BITS)) rd_shift = {rd_shift[DATA_BITS-2:0], pin};
               rd_bits = rd_bits + 1'b1;
               if (rd_bits <= BIT_CNT_W'(DATA_BITS)) begin
                  rd_clock = 1'b1;
                  rd_ticks = 16'd1;
                  rd_phase = P_HIGH;
               end else begin
                  rd_sum = rd_sum + SUM_W'(rd_shift);
                  rd_taken = rd_taken + 16'd1;
                  rd_ticks = '0;
                  if (cfg_gap == '0) end_of_reading();
                  else rd_phase = P_GAP;
               end
            end else begin
               rd_ticks = rd_ticks + 16'd1;
            end
         end
         P_GAP: begin
            rd_ticks = rd_ticks + 16'd1;
            if (rd_ticks >= cfg_gap) end_of_reading();
         end
         default: begin
            rd_phase = P_IDLE;
            rd_clock = 1'b0;
            rd_ticks = '0;
         end
      endcase
      rep.clock_pin = rd_clock;
      rep.busy = (rd_phase != P_IDLE);
      rep.done = fin_done;
      rep.average = fin_avg;
      rep.weight = fin_weight;
      tick_reports.push_back(rep);
   endfunction

   // While a reading is clocked out, the pin carries the chosen word on each sampling tick.
   function automatic logic pick_data_pin();
      logic pin;
      pin = 1'($urandom_range(0, 1));
      if (rd_phase == P_WAIT) begin
         pin = ($urandom_range(0, 2) != 0);
         if (!pin && !word_fixed) begin
            read_word = ($urandom_range(0, 5) == 0) ? {DATA_BITS{1'b1}} : DATA_BITS'($urandom());
         end
      end else if (rd_phase == P_LOW && rd_ticks >= cfg_half
                   && rd_bits < BIT_CNT_W'(DATA_BITS)) begin
         pin = read_word[DATA_BITS - 1 - rd_bits];
      end
      return pin;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_tick(input logic cmd, input logic pin, input bit steer);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      if (steer) pin = pick_data_pin();
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data_pin <= pin;
      do @(posedge clock); while (!req_ready);
      step_converter_read(cmd, pin);
      sent_items++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SAMPLE_COUNT:  cfg_readings = data[CNT_W-1:0];
         REG_TARE_VALUE:    cfg_tare = data[TARE_W-1:0];
         REG_SCALE_DIVISOR: cfg_divisor = data[DIV_W-1:0];
         REG_HALF_PERIOD:   cfg_half = data[CNT_W-1:0];
         REG_GAP_TICKS:     cfg_gap = data[CNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tick_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [CNT_W-1:0] count, input logic [TARE_W-1:0] tare,
                             input logic [DIV_W-1:0] divisor, input logic [CNT_W-1:0] half,
                             input logic [CNT_W-1:0] gap);
      wait_idle();
      write_register(REG_SAMPLE_COUNT, CSR_DAT_W'(count));
      write_register(REG_TARE_VALUE, CSR_DAT_W'(tare));
      write_register(REG_SCALE_DIVISOR, CSR_DAT_W'(divisor));
      write_register(REG_HALF_PERIOD, CSR_DAT_W'(half));
      write_register(REG_GAP_TICKS, CSR_DAT_W'(gap));
   endtask

   task automatic run_measurement(input int busy_start_pct);
      send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0);
      while (rd_phase != P_IDLE) begin
         send_tick($urandom_range(0, 99) < busy_start_pct, 1'b0, 1'b1);
      end
   endtask

   task automatic measure_word(input logic [DATA_BITS-1:0] word);
      read_word = word;
      word_fixed = 1'b1;
      run_measurement(0);
   endtask

   task automatic check_idle_ticks();
      for (int i = 0; i < 6; i++) send_tick(1'b0, 1'(i), 1'b0);
   endtask

   task automatic check_reset_defaults();
      wait_idle();
      write_register(REG_SAMPLE_COUNT, 32'd1);
      write_register(REG_HALF_PERIOD, 32'd1);
      calm = 1'b1;
      measure_word({DATA_BITS{1'b1}});
      calm = 1'b0;
   endtask

   task automatic check_word_extremes();
      set_config(16'd1, 24'd0, 32'd1, 16'd1, 16'd0);
      measure_word(24'h800001);
      measure_word('0);
   endtask

   task automatic check_zero_settings();
      set_config(16'd0, 24'd5, 32'd0, 16'd0, 16'd1);
      measure_word(24'h00F00F);
   endtask

   task automatic check_tare_edges();
      set_config(16'd1, 24'h400000, 32'd1, 16'd1, 16'd0);
      measure_word(24'h400000);
   endtask

   task automatic check_averaging();
      set_config(16'd2, 24'h000100, 32'd7, 16'd1, 16'd2);
      word_fixed = 1'b0;
      run_measurement(0);
   endtask

   task automatic check_start_while_busy();
      set_config(16'd1, 24'd0, 32'd3, 16'd1, 16'd1);
      word_fixed = 1'b0;
      run_measurement(100);
   endtask

   task automatic check_long_settings();
      set_config(16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
      repeat (3) send_tick(1'b0, 1'b0, 1'b0);
      wait_idle();
      write_register(REG_SAMPLE_COUNT, 32'hABCD_0001);
      write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
      write_register(REG_TARE_VALUE, 32'hFF00_0010);
      write_register(REG_SCALE_DIVISOR, 32'd2);
      write_register(REG_HALF_PERIOD, 32'h0001_0001);
      write_register(REG_GAP_TICKS, 32'hFFFF_0002);
      calm = 1'b1;
      measure_word(24'h0F0F0F);
      calm = 1'b0;
   endtask

   task automatic check_output_stall();
      set_config(16'd1, 24'd0, 32'd1, 16'd1, 16'd0);
      hold_left = 400;
      word_fixed = 1'b0;
      run_measurement(0);
   endtask

   task automatic check_random_runs();
      int runs;
      runs = 0;
      word_fixed = 1'b0;
      while (sent_items < 550 || runs < 1) begin
         wait_idle();
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) != 0) begin
            write_register(REG_SAMPLE_COUNT,
                           ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 3));
         end
         if ($urandom_range(0, 1) != 0) begin
            write_register(REG_TARE_VALUE, ($urandom_range(0, 1) == 0) ? 32'd0 :
                           CSR_DAT_W'($urandom_range(0, 32'hFFFFFF)));
         end
         if ($urandom_range(0, 1) != 0) begin
            case ($urandom_range(0, 9))
               0:       write_register(REG_SCALE_DIVISOR, 32'd0);
               1:       write_register(REG_SCALE_DIVISOR, $urandom());
               default: write_register(REG_SCALE_DIVISOR, $urandom_range(1, 5000));
            endcase
         end
         if ($urandom_range(0, 1) != 0) begin
            write_register(REG_HALF_PERIOD,
                           ($urandom_range(0, 4) == 0) ? 32'd2 : $urandom_range(0, 1));
         end
         if ($urandom_range(0, 1) != 0) write_register(REG_GAP_TICKS, $urandom_range(0, 3));
         repeat ($urandom_range(0, 4)) send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b0);
         run_measurement(($urandom_range(0, 3) == 0) ? 30 : 0);
         runs++;
      end
      calm = 1'b0;
   endtask

   always @(negedge clock) begin : output_side
      int roll;
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (run_left > 0) begin
         run_left = run_left - 1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            rsp_ready <= 1'b1;
            run_left = $urandom_range(0, 8);
         end else if (roll < 95) begin
            rsp_ready <= 1'b0;
            run_left = $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b0;
            run_left = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin : result_check
      tick_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tick_reports.size() == 0) begin
            $error("result item arrived with no tick outstanding");
            bad_reports++;
         end else begin
            want = tick_reports.pop_front();
            if (rsp_clock_pin !== want.clock_pin) begin
               $error("clock_pin: expected %0d, got %0d", want.clock_pin, rsp_clock_pin);
               bad_reports++;
            end
            if (rsp_busy_res !== want.busy) begin
               $error("busy_res: expected %0d, got %0d", want.busy, rsp_busy_res);
               bad_reports++;
            end
            if (rsp_done_res !== want.done) begin
               $error("done_res: expected %0d, got %0d", want.done, rsp_done_res);
               bad_reports++;
            end
            if (rsp_average_raw !== want.average) begin
               $error("average_raw: expected %0h, got %0h", want.average, rsp_average_raw);
               bad_reports++;
            end
            if (rsp_weight !== want.weight) begin
               $error("weight: expected %0d, got %0d", want.weight, rsp_weight);
               bad_reports++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)
          || (!req_valid && !csr_valid && tick_reports.size() == 0)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = 1'b0;
      req_data_pin = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_SAMPLE_COUNT;
      csr_data = '0;
      cfg_readings = SAMPLE_COUNT_RST;
      cfg_tare = TARE_VALUE_RST;
      cfg_divisor = SCALE_DIV_RST;
      cfg_half = HALF_PERIOD_RST;
      cfg_gap = GAP_TICKS_RST;
      rd_phase = P_IDLE;
      rd_ticks = '0;
      rd_bits = '0;
      rd_shift = '0;
      rd_sum = '0;
      rd_taken = '0;
      rd_clock = 1'b0;
      read_word = '0;
      word_fixed = 1'b1;
      calm = 1'b0;
      hold_left = 0;
      run_left = 0;
      bad_reports = 0;
      sent_items = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_idle_ticks();
      check_reset_defaults();
      check_word_extremes();
      check_zero_settings();
      check_tare_edges();
      check_averaging();
      check_start_while_busy();
      check_long_settings();
      check_output_stall();
      check_random_runs();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bad_reports == 0 && tick_reports.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
